/* rtl/pulse_width_amp_program_framer_unit_macros.svh */
// Assertion macros for the pulse-width programming framer.
// Used by the top level; needs nothing else.
`ifndef PULSE_WIDTH_AMP_PROGRAM_FRAMER_UNIT_MACROS_SVH
`define PULSE_WIDTH_AMP_PROGRAM_FRAMER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PWAPF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pwapf assertion failed");

// Next-cycle implication, disabled during reset.
`define PWAPF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pwapf assertion failed");

`endif

/* rtl/pwapf_pkg.sv */
// Package for the pulse-width programming framer: types, codes and frame constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pwapf_pkg;

    localparam int TIMER_WIDTH_DEF = 16;
    localparam int FRAME_LEN       = 38;
    localparam int INDEX_WIDTH     = 6;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 16;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_FUNCTION_CODE = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_OFFSET_FIELD  = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_STAGE1_FIELD  = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_STAGE2_FIELD  = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ONE_HIGH      = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ZERO_HIGH     = 3'd5;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_GAP_LOW       = 3'd6;

    localparam logic [1:0] TGT_OFFSET = 2'd0;
    localparam logic [1:0] TGT_STAGE1 = 2'd1;
    localparam logic [1:0] TGT_STAGE2 = 2'd2;

    localparam logic [1:0] FUNCTION_CODE_RST = 2'd1;
    localparam logic [1:0] OFFSET_FIELD_RST  = 2'd2;
    localparam logic [1:0] STAGE1_FIELD_RST  = 2'd0;
    localparam logic [1:0] STAGE2_FIELD_RST  = 2'd1;
    localparam int         ONE_HIGH_RST      = 80;
    localparam int         ZERO_HIGH_RST     = 1;
    localparam int         GAP_LOW_RST       = 12;

    localparam logic [11:0] START_RUN   = 12'h801;
    localparam logic [11:0] END_RUN     = 12'h7FE;
    localparam logic [1:0]  DUMMY_PAIR  = 2'b10;
    localparam logic [7:0]  STAGE1_MASK = 8'h7F;
    localparam logic [7:0]  STAGE2_MASK = 8'h07;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HIGH,
        ST_GAP,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic count;
    } timer_cmd_t;

endpackage

`default_nettype wire

/* rtl/pwapf_ifs.sv */
// Request channels of the framer: write command in, frame symbol out.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface pwapf_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] target;
    logic [7:0] value;
    logic       power_on;

    modport source (output valid, output target, output value, output power_on,
                    input ready);
    modport sink   (input valid, input target, input value, input power_on,
                    output ready);
endinterface

interface pwapf_sym_if;
    logic valid;
    logic ready;
    logic symbol;
    logic last;

    modport source (output valid, output symbol, output last, input ready);
    modport sink   (input valid, input symbol, input last, output ready);
endinterface

`default_nettype wire

/* rtl/pwapf_timer.sv */
// Shared phase timer: loads a count and runs it down to zero.
// Depends on pwapf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pwapf_timer #(
    parameter int TIMER_WIDTH = pwapf_pkg::TIMER_WIDTH_DEF
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  pwapf_pkg::timer_cmd_t       cmd,
    input  wire logic [TIMER_WIDTH-1:0] load_value,
    output logic                        done
);

    logic [TIMER_WIDTH-1:0] count_reg;
    logic [TIMER_WIDTH-1:0] count_next;

    assign done = (count_reg == '0);

    always_comb
    begin
        count_next = count_reg;
        if (cmd.load)
        begin
            count_next = load_value;
        end
        else if (cmd.count && !done)
        begin
            count_next = count_reg - TIMER_WIDTH'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/pulse_width_amp_program_framer_unit.sv */
// Pulse-width programming framer: one command in, a 38-symbol frame out, one request each.
// Each symbol follows a high phase (the one or zero high count, chosen by that symbol's value)
// and a gap phase (the gap count), all paced by one shared down-counter.
// A command with power off or target code 3 is accepted and gives no symbol.
// Reset (rst_n, async, low): idle, timer zero, registers to defaults. Uses pwapf_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "pulse_width_amp_program_framer_unit_macros.svh"

module pulse_width_amp_program_framer_unit #(
    parameter int TIMER_WIDTH = pwapf_pkg::TIMER_WIDTH_DEF
) (
    input  wire                                          clk,
    input  wire                                          rst_n,
    pwapf_cmd_if.sink                                    cmd,
    pwapf_sym_if.source                                  sym,
    input  wire                                          cfg_we,
    input  wire logic [pwapf_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  wire logic [pwapf_pkg::CFG_DATA_WIDTH-1:0]    cfg_wdata
);

    localparam int FL = pwapf_pkg::FRAME_LEN;
    localparam int IW = pwapf_pkg::INDEX_WIDTH;

    logic [1:0]             function_code_reg;
    logic [1:0]             offset_field_reg;
    logic [1:0]             stage1_field_reg;
    logic [1:0]             stage2_field_reg;
    logic [TIMER_WIDTH-1:0] one_high_reg;
    logic [TIMER_WIDTH-1:0] zero_high_reg;
    logic [TIMER_WIDTH-1:0] gap_low_reg;

    pwapf_pkg::state_t      state_reg;
    pwapf_pkg::state_t      state_next;
    logic [FL-1:0]          frame_reg;
    logic [FL-1:0]          frame_next;
    logic [IW-1:0]          symbol_index_reg;
    logic [IW-1:0]          symbol_index_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   out_symbol_reg;
    logic                   out_symbol_next;
    logic                   out_last_reg;
    logic                   out_last_next;

    pwapf_pkg::timer_cmd_t  timer_cmd;
    logic [TIMER_WIDTH-1:0] timer_load_value;
    logic                   timer_done;

    logic                   cmd_accept;
    logic                   send;
    logic [1:0]             field;
    logic [7:0]             code;
    logic                   at_last;
    logic                   out_free;

    pwapf_timer #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_timer (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (timer_cmd),
        .load_value (timer_load_value),
        .done       (timer_done)
    );

    assign cmd.ready  = (state_reg == pwapf_pkg::ST_IDLE);
    assign cmd_accept = cmd.valid && cmd.ready;
    assign sym.valid  = out_valid_reg;
    assign sym.symbol = out_symbol_reg;
    assign sym.last   = out_last_reg;
    assign at_last    = (symbol_index_reg == IW'(FL - 1));
    assign out_free   = !out_valid_reg || sym.ready;

    always_comb
    begin
        send  = cmd.power_on;
        field = offset_field_reg;
        code  = cmd.value;
        case (cmd.target)
            pwapf_pkg::TGT_OFFSET:
            begin
                field = offset_field_reg;
            end
            pwapf_pkg::TGT_STAGE1:
            begin
                field = stage1_field_reg;
                code  = cmd.value & pwapf_pkg::STAGE1_MASK;
            end
            pwapf_pkg::TGT_STAGE2:
            begin
                field = stage2_field_reg;
                code  = cmd.value & pwapf_pkg::STAGE2_MASK;
            end
            default:
            begin
                send = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next        = state_reg;
        frame_next        = frame_reg;
        symbol_index_next = symbol_index_reg;
        out_valid_next    = out_valid_reg && !sym.ready;
        out_symbol_next   = out_symbol_reg;
        out_last_next     = out_last_reg;
        timer_cmd         = '0;
        timer_load_value  = gap_low_reg;
        case (state_reg)
            pwapf_pkg::ST_IDLE:
            begin
                if (cmd_accept && send)
                begin
                    frame_next = {pwapf_pkg::START_RUN, function_code_reg, field,
                                  pwapf_pkg::DUMMY_PAIR, code, pwapf_pkg::END_RUN};
                    symbol_index_next = '0;
                    timer_cmd.load    = 1'b1;
                    timer_load_value  = pwapf_pkg::START_RUN[11] ? one_high_reg
                                                                 : zero_high_reg;
                    state_next        = pwapf_pkg::ST_HIGH;
                end
            end
            pwapf_pkg::ST_HIGH:
            begin
                timer_cmd.count = 1'b1;
                if (timer_done)
                begin
                    timer_cmd.load   = 1'b1;
                    timer_load_value = gap_low_reg;
                    state_next       = pwapf_pkg::ST_GAP;
                end
            end
            pwapf_pkg::ST_GAP:
            begin
                timer_cmd.count = 1'b1;
                if (timer_done)
                begin
                    state_next = pwapf_pkg::ST_EMIT;
                end
            end
            pwapf_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_symbol_next = frame_reg[FL-1];
                    out_last_next   = at_last;
                    frame_next      = {frame_reg[FL-2:0], 1'b0};
                    if (at_last)
                    begin
                        symbol_index_next = '0;
                        state_next        = pwapf_pkg::ST_IDLE;
                    end
                    else
                    begin
                        symbol_index_next = symbol_index_reg + IW'(1);
                        timer_cmd.load    = 1'b1;
                        timer_load_value  = frame_reg[FL-2] ? one_high_reg : zero_high_reg;
                        state_next        = pwapf_pkg::ST_HIGH;
                    end
                end
            end
            default:
            begin
                state_next = pwapf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= pwapf_pkg::ST_IDLE;
            symbol_index_reg <= '0;
            out_valid_reg    <= 1'b0;
            frame_reg        <= '0;
            out_symbol_reg   <= 1'b0;
            out_last_reg     <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            symbol_index_reg <= symbol_index_next;
            out_valid_reg    <= out_valid_next;
            frame_reg        <= frame_next;
            out_symbol_reg   <= out_symbol_next;
            out_last_reg     <= out_last_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            function_code_reg <= pwapf_pkg::FUNCTION_CODE_RST;
            offset_field_reg  <= pwapf_pkg::OFFSET_FIELD_RST;
            stage1_field_reg  <= pwapf_pkg::STAGE1_FIELD_RST;
            stage2_field_reg  <= pwapf_pkg::STAGE2_FIELD_RST;
            one_high_reg      <= TIMER_WIDTH'(pwapf_pkg::ONE_HIGH_RST);
            zero_high_reg     <= TIMER_WIDTH'(pwapf_pkg::ZERO_HIGH_RST);
            gap_low_reg       <= TIMER_WIDTH'(pwapf_pkg::GAP_LOW_RST);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pwapf_pkg::CFG_FUNCTION_CODE: function_code_reg <= cfg_wdata[1:0];
                pwapf_pkg::CFG_OFFSET_FIELD:  offset_field_reg  <= cfg_wdata[1:0];
                pwapf_pkg::CFG_STAGE1_FIELD:  stage1_field_reg  <= cfg_wdata[1:0];
                pwapf_pkg::CFG_STAGE2_FIELD:  stage2_field_reg  <= cfg_wdata[1:0];
                pwapf_pkg::CFG_ONE_HIGH:      one_high_reg      <= TIMER_WIDTH'(cfg_wdata);
                pwapf_pkg::CFG_ZERO_HIGH:     zero_high_reg     <= TIMER_WIDTH'(cfg_wdata);
                pwapf_pkg::CFG_GAP_LOW:       gap_low_reg       <= TIMER_WIDTH'(cfg_wdata);
                default:
                begin
                end
            endcase
        end
    end

    `PWAPF_ASSERT_NOW(a_last_ends_frame, clk, rst_n, out_valid_reg && out_last_reg, symbol_index_reg == '0)
    `PWAPF_ASSERT_NEXT(a_cmd_starts_frame, clk, rst_n, cmd_accept && send, state_reg == pwapf_pkg::ST_HIGH)
    `PWAPF_ASSERT_NOW(a_index_in_frame, clk, rst_n, state_reg != pwapf_pkg::ST_IDLE, symbol_index_reg < IW'(FL))
    `PWAPF_ASSERT_NEXT(a_emit_needs_gap, clk, rst_n, state_reg == pwapf_pkg::ST_GAP && !timer_done, state_reg == pwapf_pkg::ST_GAP)

endmodule

`default_nettype wire

/* dv/pwapf_frame_checker.sv */
// Frame checker for the pulse-width programming framer: watches the command,
// symbol and register ports, predicts each frame and compares it symbol by symbol.
// Depends on pwapf_pkg and the channel interfaces in pwapf_ifs.sv.
`timescale 1ns / 1ps

module pwapf_frame_checker (
    input  wire                                          clk,
    input  wire                                          rst_n,
    pwapf_cmd_if                                         cmd,
    pwapf_sym_if                                         sym,
    input  wire                                          cfg_we,
    input  wire logic [pwapf_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  wire logic [pwapf_pkg::CFG_DATA_WIDTH-1:0]    cfg_wdata,
    output int                                           failures,
    output int                                           pending,
    output int                                           symbols_checked
);

    typedef struct packed {
        logic symbol;
        logic last;
    } frame_symbol_t;

    frame_symbol_t expected_symbols[$];
    frame_symbol_t head;

    logic [1:0] fn_code;
    logic [1:0] ofs_field_code;
    logic [1:0] stage1_code;
    logic [1:0] stage2_code;

    task automatic queue_frame(input logic [1:0] tgt, input logic [7:0] val, input logic pwr);
        logic [1:0]                      field;
        logic [7:0]                      code;
        logic [pwapf_pkg::FRAME_LEN-1:0] bits;
        frame_symbol_t                   item;
        if (!pwr)
            return;
        code = val;
        case (tgt)
            pwapf_pkg::TGT_OFFSET: field = ofs_field_code;
            pwapf_pkg::TGT_STAGE1:
            begin
                field = stage1_code;
                code  = val & pwapf_pkg::STAGE1_MASK;
            end
            pwapf_pkg::TGT_STAGE2:
            begin
                field = stage2_code;
                code  = val & pwapf_pkg::STAGE2_MASK;
            end
            default: return;
        endcase
        bits = {pwapf_pkg::START_RUN, fn_code, field, pwapf_pkg::DUMMY_PAIR, code,
                pwapf_pkg::END_RUN};
        for (int k = pwapf_pkg::FRAME_LEN - 1; k >= 0; k--)
        begin
            item.symbol = bits[k];
            item.last   = (k == 0);
            expected_symbols.push_back(item);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fn_code         = pwapf_pkg::FUNCTION_CODE_RST;
            ofs_field_code  = pwapf_pkg::OFFSET_FIELD_RST;
            stage1_code     = pwapf_pkg::STAGE1_FIELD_RST;
            stage2_code     = pwapf_pkg::STAGE2_FIELD_RST;
            failures        = 0;
            symbols_checked = 0;
            expected_symbols.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    pwapf_pkg::CFG_FUNCTION_CODE: fn_code        = cfg_wdata[1:0];
                    pwapf_pkg::CFG_OFFSET_FIELD:  ofs_field_code = cfg_wdata[1:0];
                    pwapf_pkg::CFG_STAGE1_FIELD:  stage1_code    = cfg_wdata[1:0];
                    pwapf_pkg::CFG_STAGE2_FIELD:  stage2_code    = cfg_wdata[1:0];
                    default: ;
                endcase
            end
            if (cmd.valid && cmd.ready)
                queue_frame(cmd.target, cmd.value, cmd.power_on);
            if (sym.valid && sym.ready)
            begin
                symbols_checked++;
                if (expected_symbols.size() == 0)
                begin
                    $error("unexpected symbol request: symbol %0b last %0b",
                           sym.symbol, sym.last);
                    failures++;
                end
                else
                begin
                    head = expected_symbols.pop_front();
                    if (sym.symbol !== head.symbol)
                    begin
                        $error("symbol mismatch: expected %0b, actual %0b",
                               head.symbol, sym.symbol);
                        failures++;
                    end
                    if (sym.last !== head.last)
                    begin
                        $error("last mismatch: expected %0b, actual %0b",
                               head.last, sym.last);
                        failures++;
                    end
                end
            end
        end
        pending = expected_symbols.size();
    end

endmodule

/* dv/pulse_width_amp_program_framer_unit_test.sv */
// Testbench top for the pulse-width programming framer: drives write commands and
// register settings, stalls the symbol channel, and reports the verdict.
// Depends on pwapf_pkg, pwapf_ifs.sv, the framer RTL and pwapf_frame_checker.
`timescale 1ns / 1ps

module pulse_width_amp_program_framer_unit_test;

    localparam int CIW = pwapf_pkg::CFG_INDEX_WIDTH;
    localparam int CDW = pwapf_pkg::CFG_DATA_WIDTH;
    localparam logic [1:0]     TGT_UNUSED = 2'd3;
    localparam logic [CIW-1:0] CFG_SPARE  = 3'd7;
    localparam int RANDOM_FRAMES = 110;
    localparam int PHASE_FRAMES  = 40;

    logic           clk;
    logic           rst_n;
    logic           cfg_we;
    logic [CIW-1:0] cfg_index;
    logic [CDW-1:0] cfg_wdata;

    int failures;
    int pending;
    int symbols_checked;
    int frames_sent;
    int suppressed_sent;
    int burst_left;
    int ready_run;

    pwapf_cmd_if cmd_ch ();
    pwapf_sym_if sym_ch ();

    pulse_width_amp_program_framer_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .sym       (sym_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    pwapf_frame_checker u_frame_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd_ch),
        .sym             (sym_ch),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .failures        (failures),
        .pending         (pending),
        .symbols_checked (symbols_checked)
    );

    always #1 clk = ~clk;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sym_ch.ready <= 1'b0;
            ready_run    <= 0;
        end
        else if (ready_run > 0)
            ready_run <= ready_run - 1;
        else if (sym_ch.ready)
        begin
            sym_ch.ready <= 1'b0;
            ready_run    <= $urandom_range(0, 6);
        end
        else
        begin
            sym_ch.ready <= 1'b1;
            ready_run    <= ($urandom_range(0, 3) == 0) ? $urandom_range(50, 300)
                                                        : $urandom_range(0, 10);
        end
    end

    initial
    begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

    task automatic send_cmd(input logic [1:0] tgt, input logic [7:0] val, input logic pwr);
        int gap;
        cmd_ch.valid    <= 1'b1;
        cmd_ch.target   <= tgt;
        cmd_ch.value    <= val;
        cmd_ch.power_on <= pwr;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        if (pwr && tgt != TGT_UNUSED)
            frames_sent++;
        else
            suppressed_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 6);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 400) : $urandom_range(1, 8);
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // hold off until the last symbol is out and the block has gone idle
    task automatic drain();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CIW-1:0] idx, input logic [CDW-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_setting();
        drain();
        write_reg(pwapf_pkg::CFG_FUNCTION_CODE, CDW'($urandom_range(0, 3)));
        write_reg(pwapf_pkg::CFG_OFFSET_FIELD, CDW'($urandom_range(0, 3)));
        write_reg(pwapf_pkg::CFG_STAGE1_FIELD, CDW'($urandom_range(0, 3)));
        write_reg(pwapf_pkg::CFG_STAGE2_FIELD, CDW'($urandom_range(0, 3)));
        write_reg(pwapf_pkg::CFG_ONE_HIGH,
                  CDW'(($urandom_range(0, 4) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(1, 6)));
        write_reg(pwapf_pkg::CFG_ZERO_HIGH, CDW'($urandom_range(1, 4)));
        write_reg(pwapf_pkg::CFG_GAP_LOW, CDW'($urandom_range(1, 5)));
    endtask

    initial
    begin
        int         random_frames;
        int         next_setting;
        int         r;
        logic [1:0] tgt;
        logic       pwr;

        clk             = 1'b0;
        rst_n           = 1'b0;
        frames_sent     = 0;
        suppressed_sent = 0;
        burst_left      = 0;
        cmd_ch.valid    <= 1'b0;
        cmd_ch.target   <= pwapf_pkg::TGT_OFFSET;
        cmd_ch.value    <= 8'h00;
        cmd_ch.power_on <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= pwapf_pkg::CFG_FUNCTION_CODE;
        cfg_wdata       <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setting: value extremes, masking, suppressed commands
        send_cmd(pwapf_pkg::TGT_OFFSET, 8'h00, 1'b1);
        send_cmd(pwapf_pkg::TGT_OFFSET, 8'hFF, 1'b1);
        send_cmd(pwapf_pkg::TGT_STAGE1, 8'hFF, 1'b1);
        send_cmd(pwapf_pkg::TGT_STAGE1, 8'h80, 1'b1);
        send_cmd(pwapf_pkg::TGT_STAGE2, 8'hFF, 1'b1);
        send_cmd(pwapf_pkg::TGT_STAGE2, 8'hF8, 1'b1);
        send_cmd(pwapf_pkg::TGT_STAGE2, 8'h05, 1'b1);
        send_cmd(pwapf_pkg::TGT_OFFSET, 8'hA5, 1'b0);
        send_cmd(TGT_UNUSED, 8'h3C, 1'b1);
        send_cmd(TGT_UNUSED, 8'hFF, 1'b0);
        send_cmd(pwapf_pkg::TGT_STAGE1, 8'h55, 1'b1);

        // shortest timing, low function code, high field codes
        drain();
        write_reg(pwapf_pkg::CFG_FUNCTION_CODE, 16'd0);
        write_reg(pwapf_pkg::CFG_OFFSET_FIELD, 16'd3);
        write_reg(pwapf_pkg::CFG_STAGE1_FIELD, 16'd3);
        write_reg(pwapf_pkg::CFG_STAGE2_FIELD, 16'd3);
        write_reg(pwapf_pkg::CFG_ONE_HIGH, 16'd1);
        write_reg(pwapf_pkg::CFG_ZERO_HIGH, 16'd1);
        write_reg(pwapf_pkg::CFG_GAP_LOW, 16'd1);
        write_reg(CFG_SPARE, 16'hFFFF);
        send_cmd(pwapf_pkg::TGT_OFFSET, 8'hFF, 1'b1);
        send_cmd(pwapf_pkg::TGT_STAGE1, 8'h7F, 1'b1);
        send_cmd(pwapf_pkg::TGT_STAGE2, 8'h07, 1'b1);
        send_cmd(pwapf_pkg::TGT_OFFSET, 8'h00, 1'b1);

        drain();
        write_reg(pwapf_pkg::CFG_FUNCTION_CODE, 16'd3);
        write_reg(pwapf_pkg::CFG_OFFSET_FIELD, 16'd0);
        write_reg(pwapf_pkg::CFG_STAGE1_FIELD, 16'd0);
        write_reg(pwapf_pkg::CFG_STAGE2_FIELD, 16'd0);
        write_reg(pwapf_pkg::CFG_ONE_HIGH, 16'd3);
        write_reg(pwapf_pkg::CFG_ZERO_HIGH, 16'd2);
        write_reg(pwapf_pkg::CFG_GAP_LOW, 16'd4);
        send_cmd(pwapf_pkg::TGT_STAGE1, 8'h81, 1'b1);
        send_cmd(pwapf_pkg::TGT_STAGE2, 8'h5A, 1'b1);
        send_cmd(pwapf_pkg::TGT_OFFSET, 8'h3C, 1'b1);

        random_frames = 0;
        next_setting  = 0;
        while (random_frames < RANDOM_FRAMES)
        begin
            if (random_frames >= next_setting)
            begin
                random_setting();
                next_setting += PHASE_FRAMES;
            end
            r   = $urandom_range(0, 19);
            tgt = (r == 0) ? TGT_UNUSED : 2'($urandom_range(0, 2));
            pwr = (r == 1 || r == 2) ? 1'b0 : 1'b1;
            send_cmd(tgt, 8'($urandom_range(0, 255)), pwr);
            if (pwr && tgt != TGT_UNUSED)
                random_frames++;
        end

        // largest timing values; only one frame with few long pulses
        drain();
        write_reg(pwapf_pkg::CFG_ONE_HIGH, 16'hFFFF);
        write_reg(pwapf_pkg::CFG_ZERO_HIGH, 16'hFFFF);
        write_reg(pwapf_pkg::CFG_GAP_LOW, 16'hFFFF);
        send_cmd(pwapf_pkg::TGT_STAGE2, 8'hC3, 1'b0);
        send_cmd(TGT_UNUSED, 8'h00, 1'b1);
        drain();
        write_reg(pwapf_pkg::CFG_ZERO_HIGH, 16'd1);
        write_reg(pwapf_pkg::CFG_GAP_LOW, 16'd1);
        write_reg(pwapf_pkg::CFG_FUNCTION_CODE, 16'd0);
        write_reg(pwapf_pkg::CFG_OFFSET_FIELD, 16'd0);
        send_cmd(pwapf_pkg::TGT_OFFSET, 8'h00, 1'b1);

        drain();
        repeat (200) @(posedge clk);

        $display("covered %0d frames (%0d symbols checked) and %0d suppressed commands",
                 frames_sent, symbols_checked, suppressed_sent);
        $display("settings: reset, shortest and longest pulse timing, all codes 0..3, spare index");
        if (failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/pwapf_pkg.sv
rtl/pwapf_ifs.sv
rtl/pwapf_timer.sv
rtl/pulse_width_amp_program_framer_unit.sv
dv/pwapf_frame_checker.sv
dv/pulse_width_amp_program_framer_unit_test.sv
